FILE: rtl/core/rotor_cipher_machine_assert.svh
// ----------------------------------------------------------------------------
// rotor_cipher_machine_assert.svh
// Assertion macros used by the rotor cipher machine checker.
// ----------------------------------------------------------------------------
`ifndef ROTOR_CIPHER_MACHINE_ASSERT_SVH
`define ROTOR_CIPHER_MACHINE_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define RCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define RCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rcm_pkg.sv
// ----------------------------------------------------------------------------
// rcm_pkg
// Types, codes, wheel tables and modulo-26 helpers of the rotor cipher machine.
// ----------------------------------------------------------------------------
package rcm_pkg;

    localparam int ALPHA      = 26;
    localparam int NUM_WHEELS = 5;
    localparam int CMD_DEPTH  = 4;
    localparam int OUT_DEPTH  = 8;

    // operation codes on the input port
    localparam logic [2:0] OP_ENCIPHER = 3'd0;
    localparam logic [2:0] OP_PEEK     = 3'd1;
    localparam logic [2:0] OP_STEP     = 3'd2;
    localparam logic [2:0] OP_LOAD     = 3'd3;
    localparam logic [2:0] OP_PLUG     = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    // command kinds after classification
    localparam logic [2:0] K_ENC   = 3'd0;
    localparam logic [2:0] K_PEEK  = 3'd1;
    localparam logic [2:0] K_STEP  = 3'd2;
    localparam logic [2:0] K_LOAD  = 3'd3;
    localparam logic [2:0] K_PLUG  = 3'd4;
    localparam logic [2:0] K_CLEAR = 3'd5;
    localparam logic [2:0] K_NOP   = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_LEFT_WHEEL   = 3'd0;
    localparam logic [2:0] REG_MIDDLE_WHEEL = 3'd1;
    localparam logic [2:0] REG_RIGHT_WHEEL  = 3'd2;
    localparam logic [2:0] REG_LEFT_RING    = 3'd3;
    localparam logic [2:0] REG_MIDDLE_RING  = 3'd4;
    localparam logic [2:0] REG_RIGHT_RING   = 3'd5;

    localparam logic [2:0] WHEEL_I    = 3'd0;
    localparam logic [2:0] WHEEL_II   = 3'd1;
    localparam logic [2:0] WHEEL_III  = 3'd2;
    localparam logic [2:0] WHEEL_LAST = 3'd4;

    localparam logic [7:0] LETTER_A = 8'h41;

    localparam logic [NUM_WHEELS-1:0][8*ALPHA-1:0] WIRING = {
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ"
    };
    localparam logic [8*ALPHA-1:0]      REFLECTOR_B = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
    localparam logic [8*NUM_WHEELS-1:0] NOTCHES     = "QEVJZ";

    typedef struct packed {
        logic [2:0] left_wheel;
        logic [2:0] middle_wheel;
        logic [2:0] right_wheel;
        logic [4:0] left_ring;
        logic [4:0] middle_ring;
        logic [4:0] right_ring;
    } t_cfg;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] letter;
        logic [4:0] partner;
        logic [4:0] new_l;
        logic [4:0] new_m;
        logic [4:0] new_r;
    } t_cmd;

    typedef struct packed {
        logic [4:0] letter;
        logic [4:0] shown_l;
        logic [4:0] shown_m;
        logic [4:0] shown_r;
    } t_res;

    function automatic logic [4:0] mod26(input logic [4:0] x);
        return (x >= 5'(ALPHA)) ? x - 5'(ALPHA) : x;
    endfunction

    function automatic logic [4:0] add_mod(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 6'(ALPHA)) begin
            s = s - 6'(ALPHA);
        end
        return s[4:0];
    endfunction

    function automatic logic [4:0] sub_mod(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] t;
        t = {1'b0, a} + 6'(ALPHA) - {1'b0, b};
        if (t >= 6'(ALPHA)) begin
            t = t - 6'(ALPHA);
        end
        return t[4:0];
    endfunction

    function automatic logic [2:0] clamp_wheel(input logic [2:0] w);
        return (w > WHEEL_LAST) ? WHEEL_LAST : w;
    endfunction

    function automatic logic [4:0] notch(input logic [2:0] w);
        logic [7:0] ch;
        ch = NOTCHES[8*(NUM_WHEELS-1-int'(w)) +: 8];
        return 5'(ch - LETTER_A);
    endfunction

    function automatic logic [4:0] fwd_map(input logic [2:0] w, input logic [4:0] x);
        logic [7:0] ch;
        ch = WIRING[w][8*(ALPHA-1-int'(x)) +: 8];
        return 5'(ch - LETTER_A);
    endfunction

    function automatic logic [4:0] rev_map(input logic [2:0] w, input logic [4:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < ALPHA; i++) begin
            if (fwd_map(w, 5'(i)) == x) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] reflect(input logic [4:0] x);
        logic [7:0] ch;
        ch = REFLECTOR_B[8*(ALPHA-1-int'(x)) +: 8];
        return 5'(ch - LETTER_A);
    endfunction

    // d is the wheel position minus its ring setting, modulo 26
    function automatic logic [4:0] pass_fwd(input logic [2:0] w, input logic [4:0] d,
                                            input logic [4:0] x);
        return sub_mod(fwd_map(w, add_mod(x, d)), d);
    endfunction

    function automatic logic [4:0] pass_back(input logic [2:0] w, input logic [4:0] d,
                                             input logic [4:0] x);
        return sub_mod(rev_map(w, add_mod(x, d)), d);
    endfunction

endpackage

FILE: rtl/core/rcm_queue.sv
// ----------------------------------------------------------------------------
// rcm_queue
// Small show-ahead FIFO in flip-flops with occupancy count.
// ----------------------------------------------------------------------------
module rcm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

FILE: rtl/core/rcm_front.sv
// ----------------------------------------------------------------------------
// rcm_front
// Accepts input transactions, classifies the operation, folds fields into
// range and queues the resulting commands for the back end.
// ----------------------------------------------------------------------------
module rcm_front #(
    parameter int CMD_DEPTH = rcm_pkg::CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [2:0]    i_operation,
    input  logic [4:0]    i_letter,
    input  logic [4:0]    i_partner_letter,
    input  logic [4:0]    i_new_left,
    input  logic [4:0]    i_new_middle,
    input  logic [4:0]    i_new_right,
    output logic          o_cmd_valid,
    output rcm_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    rcm_pkg::t_cmd cmd;
    logic          cmd_empty;
    logic [$bits(rcm_pkg::t_cmd)-1:0] cmd_bits;

    always_comb begin
        cmd.letter  = rcm_pkg::mod26(i_letter);
        cmd.partner = rcm_pkg::mod26(i_partner_letter);
        cmd.new_l   = rcm_pkg::mod26(i_new_left);
        cmd.new_m   = rcm_pkg::mod26(i_new_middle);
        cmd.new_r   = rcm_pkg::mod26(i_new_right);
        case (i_operation)
            rcm_pkg::OP_ENCIPHER: cmd.kind = rcm_pkg::K_ENC;
            rcm_pkg::OP_PEEK:     cmd.kind = rcm_pkg::K_PEEK;
            rcm_pkg::OP_STEP:     cmd.kind = rcm_pkg::K_STEP;
            rcm_pkg::OP_LOAD:     cmd.kind = rcm_pkg::K_LOAD;
            rcm_pkg::OP_PLUG: begin
                // drop a pair that names a letter out of range
                if (i_letter < 5'(rcm_pkg::ALPHA) && i_partner_letter < 5'(rcm_pkg::ALPHA)) begin
                    cmd.kind = rcm_pkg::K_PLUG;
                end else begin
                    cmd.kind = rcm_pkg::K_NOP;
                end
            end
            rcm_pkg::OP_CLEAR:    cmd.kind = rcm_pkg::K_CLEAR;
            default:              cmd.kind = rcm_pkg::K_NOP;
        endcase
    end

    rcm_queue #(
        .WIDTH ($bits(rcm_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (cmd),
        .i_rd    (i_cmd_pop),
        .o_rdata (cmd_bits),
        .o_full  (o_full),
        .o_empty (cmd_empty),
        .o_count ()
    );

    assign o_cmd       = rcm_pkg::t_cmd'(cmd_bits);
    assign o_cmd_valid = !cmd_empty;

endmodule

FILE: rtl/core/rcm_back.sv
// ----------------------------------------------------------------------------
// rcm_back
// Executes commands: rotor stepping and loading, plugboard updates, and a
// four-stage pipeline for the letter path through wheels and reflector.
// ----------------------------------------------------------------------------
module rcm_back #(
    parameter int OUT_DEPTH = rcm_pkg::OUT_DEPTH,
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcm_pkg::t_cfg     i_cfg,
    input  logic              i_cmd_valid,
    input  rcm_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    input  logic [OCNT_W-1:0] i_out_count,
    output logic              o_res_valid,
    output rcm_pkg::t_res     o_res
);

    localparam int PIPE_STAGES = 4;
    localparam int SUM_W       = $clog2(OUT_DEPTH + PIPE_STAGES + 1);

    typedef struct packed {
        logic       cipher;
        logic [4:0] x;
        logic [4:0] d_l;
        logic [4:0] d_m;
        logic [4:0] d_r;
        logic [4:0] pos_l;
        logic [4:0] pos_m;
        logic [4:0] pos_r;
    } t_stage;

    logic [4:0]             r_off_l;
    logic [4:0]             r_off_m;
    logic [4:0]             r_off_r;
    logic [4:0]             r_plug_in  [rcm_pkg::ALPHA];
    logic [4:0]             r_plug_out [rcm_pkg::ALPHA];
    logic [PIPE_STAGES-1:0] r_vld;
    t_stage                 r_stage [PIPE_STAGES];
    t_stage                 n_stage [PIPE_STAGES];

    logic       mid_notch;
    logic       right_notch;
    logic [4:0] n_off_l;
    logic [4:0] n_off_m;
    logic [4:0] n_off_r;
    logic       is_plug;
    logic       credit_ok;
    logic       issue;
    logic [SUM_W-1:0] in_use;

    always_comb begin
        mid_notch   = (r_off_m == rcm_pkg::notch(i_cfg.middle_wheel));
        right_notch = (r_off_r == rcm_pkg::notch(i_cfg.right_wheel));
        n_off_l = r_off_l;
        n_off_m = r_off_m;
        n_off_r = r_off_r;
        case (i_cmd.kind)
            rcm_pkg::K_ENC, rcm_pkg::K_STEP: begin
                // middle wheel at its notch carries itself and the left wheel
                if (mid_notch) begin
                    n_off_l = rcm_pkg::add_mod(r_off_l, 5'd1);
                end
                if (mid_notch || right_notch) begin
                    n_off_m = rcm_pkg::add_mod(r_off_m, 5'd1);
                end
                n_off_r = rcm_pkg::add_mod(r_off_r, 5'd1);
            end
            rcm_pkg::K_LOAD: begin
                n_off_l = i_cmd.new_l;
                n_off_m = i_cmd.new_m;
                n_off_r = i_cmd.new_r;
            end
            default: ;
        endcase

        // plugboard writes wait until no letter is left in the pipeline
        is_plug   = (i_cmd.kind == rcm_pkg::K_PLUG) || (i_cmd.kind == rcm_pkg::K_CLEAR);
        in_use    = SUM_W'(i_out_count) + SUM_W'($countones(r_vld));
        credit_ok = (in_use < SUM_W'(OUT_DEPTH));
        issue     = i_cmd_valid && credit_ok && !(is_plug && (|r_vld));
        o_cmd_pop = issue;

        n_stage[0].cipher = (i_cmd.kind == rcm_pkg::K_ENC) || (i_cmd.kind == rcm_pkg::K_PEEK);
        n_stage[0].x      = r_plug_in[i_cmd.letter];
        n_stage[0].d_l    = rcm_pkg::sub_mod(n_off_l, i_cfg.left_ring);
        n_stage[0].d_m    = rcm_pkg::sub_mod(n_off_m, i_cfg.middle_ring);
        n_stage[0].d_r    = rcm_pkg::sub_mod(n_off_r, i_cfg.right_ring);
        n_stage[0].pos_l  = n_off_l;
        n_stage[0].pos_m  = n_off_m;
        n_stage[0].pos_r  = n_off_r;

        // right and middle wheels toward the reflector
        n_stage[1]   = r_stage[0];
        n_stage[1].x = rcm_pkg::pass_fwd(i_cfg.middle_wheel, r_stage[0].d_m,
                       rcm_pkg::pass_fwd(i_cfg.right_wheel, r_stage[0].d_r, r_stage[0].x));

        // left wheel, reflector, left wheel back
        n_stage[2]   = r_stage[1];
        n_stage[2].x = rcm_pkg::pass_back(i_cfg.left_wheel, r_stage[1].d_l,
                       rcm_pkg::reflect(
                       rcm_pkg::pass_fwd(i_cfg.left_wheel, r_stage[1].d_l, r_stage[1].x)));

        // middle and right wheels on the way back
        n_stage[3]   = r_stage[2];
        n_stage[3].x = rcm_pkg::pass_back(i_cfg.right_wheel, r_stage[2].d_r,
                       rcm_pkg::pass_back(i_cfg.middle_wheel, r_stage[2].d_m, r_stage[2].x));

        o_res_valid   = r_vld[PIPE_STAGES-1];
        o_res.letter  = r_stage[PIPE_STAGES-1].cipher ?
                        r_plug_out[r_stage[PIPE_STAGES-1].x] : '0;
        o_res.shown_l = r_stage[PIPE_STAGES-1].pos_l;
        o_res.shown_m = r_stage[PIPE_STAGES-1].pos_m;
        o_res.shown_r = r_stage[PIPE_STAGES-1].pos_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_l <= '0;
            r_off_m <= '0;
            r_off_r <= '0;
            r_vld   <= '0;
            for (int i = 0; i < rcm_pkg::ALPHA; i++) begin
                r_plug_in[i]  <= 5'(i);
                r_plug_out[i] <= 5'(i);
            end
        end else begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], issue};
            if (issue) begin
                r_off_l <= n_off_l;
                r_off_m <= n_off_m;
                r_off_r <= n_off_r;
                if (i_cmd.kind == rcm_pkg::K_PLUG) begin
                    r_plug_in[i_cmd.letter]   <= i_cmd.partner;
                    r_plug_in[i_cmd.partner]  <= i_cmd.letter;
                    r_plug_out[i_cmd.letter]  <= i_cmd.partner;
                    r_plug_out[i_cmd.partner] <= i_cmd.letter;
                end else if (i_cmd.kind == rcm_pkg::K_CLEAR) begin
                    for (int i = 0; i < rcm_pkg::ALPHA; i++) begin
                        r_plug_in[i]  <= 5'(i);
                        r_plug_out[i] <= 5'(i);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            r_stage[k] <= n_stage[k];
        end
    end

endmodule

FILE: rtl/core/rotor_cipher_machine.sv
// ----------------------------------------------------------------------------
// rotor_cipher_machine
// Three-rotor cipher machine, wheels I to V, reflector B, plugboard.
//
//   channel   handshake             payload
//   --------  --------------------  -----------------------------------------
//   command   push / full           operation, letter, partner_letter,
//                                   new_left, new_middle, new_right
//   result    empty / pop           out_letter, shown_left/middle/right
//   config    i_cfg_wen             i_cfg_idx, i_cfg_wdata (no read-back)
//
// One transaction per cycle in while not full and out while not empty; a
// result passes through the command queue, the four-stage letter pipeline
// and the result queue. A plug pair or plug clear waits for an empty letter
// pipeline. Synchronous reset restores wheels I, II, III, rings zero,
// positions zero and an empty plugboard. A stalled result side fills the
// result queue, then the command queue, then raises full.
// ----------------------------------------------------------------------------
module rotor_cipher_machine #(
    parameter int CMD_DEPTH = rcm_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH = rcm_pkg::OUT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_operation,
    input  logic [4:0] i_letter,
    input  logic [4:0] i_partner_letter,
    input  logic [4:0] i_new_left,
    input  logic [4:0] i_new_middle,
    input  logic [4:0] i_new_right,
    output logic       empty,
    input  logic       pop,
    output logic [4:0] o_out_letter,
    output logic [4:0] o_shown_left,
    output logic [4:0] o_shown_middle,
    output logic [4:0] o_shown_right,
    input  logic       i_cfg_wen,
    input  logic [2:0] i_cfg_idx,
    input  logic [4:0] i_cfg_wdata
);

    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    rcm_pkg::t_cfg     r_cfg;
    rcm_pkg::t_cmd     cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    logic              res_valid;
    rcm_pkg::t_res     res;
    rcm_pkg::t_res     head;
    logic [OCNT_W-1:0] out_count;
    logic [$bits(rcm_pkg::t_res)-1:0] head_bits;

    // store wheels clamped and rings folded, so the datapath sees legal values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_wheel   <= rcm_pkg::WHEEL_I;
            r_cfg.middle_wheel <= rcm_pkg::WHEEL_II;
            r_cfg.right_wheel  <= rcm_pkg::WHEEL_III;
            r_cfg.left_ring    <= '0;
            r_cfg.middle_ring  <= '0;
            r_cfg.right_ring   <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                rcm_pkg::REG_LEFT_WHEEL:   r_cfg.left_wheel   <= rcm_pkg::clamp_wheel(i_cfg_wdata[2:0]);
                rcm_pkg::REG_MIDDLE_WHEEL: r_cfg.middle_wheel <= rcm_pkg::clamp_wheel(i_cfg_wdata[2:0]);
                rcm_pkg::REG_RIGHT_WHEEL:  r_cfg.right_wheel  <= rcm_pkg::clamp_wheel(i_cfg_wdata[2:0]);
                rcm_pkg::REG_LEFT_RING:    r_cfg.left_ring    <= rcm_pkg::mod26(i_cfg_wdata);
                rcm_pkg::REG_MIDDLE_RING:  r_cfg.middle_ring  <= rcm_pkg::mod26(i_cfg_wdata);
                rcm_pkg::REG_RIGHT_RING:   r_cfg.right_ring   <= rcm_pkg::mod26(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    rcm_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_operation      (i_operation),
        .i_letter         (i_letter),
        .i_partner_letter (i_partner_letter),
        .i_new_left       (i_new_left),
        .i_new_middle     (i_new_middle),
        .i_new_right      (i_new_right),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_pop        (cmd_pop)
    );

    rcm_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rcm_queue #(
        .WIDTH ($bits(rcm_pkg::t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res),
        .i_rd    (pop),
        .o_rdata (head_bits),
        .o_full  (),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign head           = rcm_pkg::t_res'(head_bits);
    assign o_out_letter   = head.letter;
    assign o_shown_left   = head.shown_l;
    assign o_shown_middle = head.shown_m;
    assign o_shown_right  = head.shown_r;

endmodule

FILE: rtl/core/rcm_checker.sv
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks of the rotor cipher machine, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotor_cipher_machine_assert.svh"

module rcm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [4:0] o_out_letter,
    input logic [4:0] o_shown_left,
    input logic [4:0] o_shown_middle,
    input logic [4:0] o_shown_right
);

    logic [19:0] head_fields;
    logic        head_in_range;

    assign head_fields   = {o_out_letter, o_shown_left, o_shown_middle, o_shown_right};
    assign head_in_range = (o_out_letter < 5'(rcm_pkg::ALPHA))
                        && (o_shown_left < 5'(rcm_pkg::ALPHA))
                        && (o_shown_middle < 5'(rcm_pkg::ALPHA))
                        && (o_shown_right < 5'(rcm_pkg::ALPHA));

    // every shown letter and position is a letter of the alphabet
    `RCM_ASSERT_IMP(a_res_range, !empty, head_in_range, "result field out of range")

    // a waiting result holds until popped
    `RCM_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(head_fields), "waiting result changed")

    // a full command queue with nothing waiting must yield a result soon
    `RCM_ASSERT_NXT(a_drain, (full && empty) ##1 empty [*4], !empty, "commands queued, no result")

endmodule

bind rotor_cipher_machine rcm_checker u_rcm_checker (.*);

FILE: tb/tb_rotor_cipher_machine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rotor_cipher_machine
// Self-checking bench for the three-rotor cipher machine. A short table of
// hand-picked commands runs first. Random command streams follow under
// several wheel and ring settings and under several stall patterns on the
// command and result queues. Results are scored against an in-bench model
// of the wheel wiring, the stepping and the plugboard, or a row's own want.
// ---------------------------------------------------------------------------
module tb_rotor_cipher_machine;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 42;
    localparam int BURST_ITEMS    = 40;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_REPORTS    = 40;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam logic [2:0] WHEEL_IV    = 3'd3;

    localparam int LEFT   = 0;
    localparam int MIDDLE = 1;
    localparam int RIGHT  = 2;

    localparam byte CHAR_A = "A";

    typedef struct packed {
        logic [4:0] letter;
        logic [4:0] left;
        logic [4:0] middle;
        logic [4:0] right;
    } t_dial_reading;

    typedef struct packed {
        logic [2:0]    op;
        logic [4:0]    letter;
        logic [4:0]    partner;
        logic [4:0]    new_left;
        logic [4:0]    new_middle;
        logic [4:0]    new_right;
        logic          has_want;
        t_dial_reading want;
    } t_command;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       push             = 1'b0;
    logic       full;
    logic [2:0] i_operation      = rcm_pkg::OP_ENCIPHER;
    logic [4:0] i_letter         = '0;
    logic [4:0] i_partner_letter = '0;
    logic [4:0] i_new_left       = '0;
    logic [4:0] i_new_middle     = '0;
    logic [4:0] i_new_right      = '0;
    logic       empty;
    logic       pop              = 1'b0;
    logic [4:0] o_out_letter;
    logic [4:0] o_shown_left;
    logic [4:0] o_shown_middle;
    logic [4:0] o_shown_right;
    logic       i_cfg_wen        = 1'b0;
    logic [2:0] i_cfg_idx        = rcm_pkg::REG_LEFT_WHEEL;
    logic [4:0] i_cfg_wdata      = '0;

    // typed-in expectation that travels with a table row
    logic          row_has_want = 1'b0;
    t_dial_reading row_want     = '0;

    // machine model state
    logic [2:0] slot_wheel [3];
    logic [4:0] slot_ring  [3];
    logic [4:0] rotor_pos  [3];
    logic [4:0] plugboard  [rcm_pkg::ALPHA];

    string reflector_wiring = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
    string notch_letters    = "QEVJZ";

    t_dial_reading pending_readings [$];
    t_command      drill_rows [$];

    int mismatches   = 0;
    int results_seen = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    rotor_cipher_machine uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_operation      (i_operation),
        .i_letter         (i_letter),
        .i_partner_letter (i_partner_letter),
        .i_new_left       (i_new_left),
        .i_new_middle     (i_new_middle),
        .i_new_right      (i_new_right),
        .empty            (empty),
        .pop              (pop),
        .o_out_letter     (o_out_letter),
        .o_shown_left     (o_shown_left),
        .o_shown_middle   (o_shown_middle),
        .o_shown_right    (o_shown_right),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic string wheel_wiring(logic [2:0] w);
        case (w)
            rcm_pkg::WHEEL_I:   return "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
            rcm_pkg::WHEEL_II:  return "AJDKSIRUXBLHWTMCQGZNPYFVOE";
            rcm_pkg::WHEEL_III: return "BDFHJLCPRTXVZNYEIWGAKMUSQO";
            WHEEL_IV:           return "ESOVPZJAYQUIRHXLNFTGKDCMWB";
            default:            return "VZBRGITYUPSDNHLXAWMJQOFECK";
        endcase
    endfunction

    function automatic int letter_index(string s, int i);
        return int'(s[i]) - int'(CHAR_A);
    endfunction

    function automatic int notch_of(logic [2:0] w);
        return letter_index(notch_letters,
                            int'((w > rcm_pkg::WHEEL_LAST) ? rcm_pkg::WHEEL_LAST : w));
    endfunction

    // one wheel, toward the reflector or back from it
    function automatic int rotor_pass(int slot, int x, bit back);
        string s;
        int    r;
        int    p;
        int    i;
        int    m;
        s = wheel_wiring(slot_wheel[slot]);
        r = int'(slot_ring[slot]) % rcm_pkg::ALPHA;
        p = int'(rotor_pos[slot]);
        i = (x + p + rcm_pkg::ALPHA - r) % rcm_pkg::ALPHA;
        m = 0;
        if (back) begin
            for (int k = 0; k < rcm_pkg::ALPHA; k++) begin
                if (letter_index(s, k) == i) begin
                    m = k;
                end
            end
        end else begin
            m = letter_index(s, i);
        end
        return (m + rcm_pkg::ALPHA + r - p) % rcm_pkg::ALPHA;
    endfunction

    function automatic int translate_letter(int c);
        int x;
        x = int'(plugboard[c % rcm_pkg::ALPHA]);
        x = rotor_pass(RIGHT, x, 1'b0);
        x = rotor_pass(MIDDLE, x, 1'b0);
        x = rotor_pass(LEFT, x, 1'b0);
        x = letter_index(reflector_wiring, x);
        x = rotor_pass(LEFT, x, 1'b1);
        x = rotor_pass(MIDDLE, x, 1'b1);
        x = rotor_pass(RIGHT, x, 1'b1);
        return int'(plugboard[x]);
    endfunction

    function automatic void advance_rotors();
        bit mid_at_notch;
        bit right_at_notch;
        mid_at_notch   = int'(rotor_pos[MIDDLE]) == notch_of(slot_wheel[MIDDLE]);
        right_at_notch = int'(rotor_pos[RIGHT]) == notch_of(slot_wheel[RIGHT]);
        // middle wheel at its notch drags itself and the left wheel along
        if (mid_at_notch) begin
            rotor_pos[LEFT]   = 5'((rotor_pos[LEFT] + 1) % rcm_pkg::ALPHA);
            rotor_pos[MIDDLE] = 5'((rotor_pos[MIDDLE] + 1) % rcm_pkg::ALPHA);
        end else if (right_at_notch) begin
            rotor_pos[MIDDLE] = 5'((rotor_pos[MIDDLE] + 1) % rcm_pkg::ALPHA);
        end
        rotor_pos[RIGHT] = 5'((rotor_pos[RIGHT] + 1) % rcm_pkg::ALPHA);
    endfunction

    function automatic t_dial_reading crank_machine(t_command c);
        t_dial_reading shown;
        shown = '0;
        case (c.op)
            rcm_pkg::OP_ENCIPHER: begin
                advance_rotors();
                shown.letter = 5'(translate_letter(int'(c.letter)));
            end
            rcm_pkg::OP_PEEK: begin
                shown.letter = 5'(translate_letter(int'(c.letter)));
            end
            rcm_pkg::OP_STEP: begin
                advance_rotors();
            end
            rcm_pkg::OP_LOAD: begin
                rotor_pos[LEFT]   = 5'(int'(c.new_left) % rcm_pkg::ALPHA);
                rotor_pos[MIDDLE] = 5'(int'(c.new_middle) % rcm_pkg::ALPHA);
                rotor_pos[RIGHT]  = 5'(int'(c.new_right) % rcm_pkg::ALPHA);
            end
            rcm_pkg::OP_PLUG: begin
                // drop the pair if either letter is off the alphabet
                if (int'(c.letter) < rcm_pkg::ALPHA && int'(c.partner) < rcm_pkg::ALPHA) begin
                    plugboard[c.letter]  = c.partner;
                    plugboard[c.partner] = c.letter;
                end
            end
            rcm_pkg::OP_CLEAR: begin
                for (int k = 0; k < rcm_pkg::ALPHA; k++) begin
                    plugboard[k] = 5'(k);
                end
            end
            default: begin
            end
        endcase
        shown.left   = rotor_pos[LEFT];
        shown.middle = rotor_pos[MIDDLE];
        shown.right  = rotor_pos[RIGHT];
        return shown;
    endfunction

    function automatic t_command random_command();
        t_command c;
        int       pick;
        c.letter     = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                                   : 5'($urandom_range(0, 25));
        c.partner    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                                   : 5'($urandom_range(0, 25));
        c.new_left   = 5'($urandom);
        c.new_middle = 5'($urandom);
        c.new_right  = 5'($urandom);
        c.has_want   = 1'b0;
        c.want       = '0;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            c.op = rcm_pkg::OP_ENCIPHER;
        end else if (pick < 55) begin
            c.op = rcm_pkg::OP_PEEK;
        end else if (pick < 63) begin
            c.op = rcm_pkg::OP_STEP;
        end else if (pick < 75) begin
            c.op = rcm_pkg::OP_LOAD;
        end else if (pick < 88) begin
            c.op = rcm_pkg::OP_PLUG;
        end else if (pick < 93) begin
            c.op = rcm_pkg::OP_CLEAR;
        end else if (pick < 97) begin
            c.op = OP_UNUSED_6;
        end else begin
            c.op = OP_UNUSED_7;
        end
        // park the wheels at or just before their notches for the double step
        if (c.op == rcm_pkg::OP_LOAD && $urandom_range(0, 1) == 1) begin
            c.new_middle = 5'((notch_of(slot_wheel[MIDDLE]) + rcm_pkg::ALPHA
                               - int'($urandom_range(0, 1))) % rcm_pkg::ALPHA);
            c.new_right  = 5'((notch_of(slot_wheel[RIGHT]) + rcm_pkg::ALPHA
                               - int'($urandom_range(0, 3))) % rcm_pkg::ALPHA);
        end
        return c;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < MAX_REPORTS) begin
            $display("%0d ns mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic add_row(logic [2:0] op, int a, int b, int l, int m, int r,
                           bit has_want, int w_letter, int w_l, int w_m, int w_r);
        t_command c;
        c.op         = op;
        c.letter     = 5'(a);
        c.partner    = 5'(b);
        c.new_left   = 5'(l);
        c.new_middle = 5'(m);
        c.new_right  = 5'(r);
        c.has_want   = has_want;
        c.want       = {5'(w_letter), 5'(w_l), 5'(w_m), 5'(w_r)};
        drill_rows.push_back(c);
    endtask

    task automatic offer_command(t_command c);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_operation      <= c.op;
        i_letter         <= c.letter;
        i_partner_letter <= c.partner;
        i_new_left       <= c.new_left;
        i_new_middle     <= c.new_middle;
        i_new_right      <= c.new_right;
        row_has_want     <= c.has_want;
        row_want         <= c.want;
        do @(posedge i_clk); while (full);
    endtask

    // hold the command side until every result is back and the pipe is quiet
    task automatic settle_machine();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(int p);
        rcm_pkg::t_cfg s;
        logic [4:0]    value;
        case (p)
            0: s = {rcm_pkg::WHEEL_I, rcm_pkg::WHEEL_II, rcm_pkg::WHEEL_III,
                    5'd0, 5'd0, 5'd0};
            1: s = {rcm_pkg::WHEEL_LAST, rcm_pkg::WHEEL_LAST, rcm_pkg::WHEEL_LAST,
                    5'd25, 5'd25, 5'd25};
            2: s = {3'd7, 3'd6, 3'd5, 5'd31, 5'd26, 5'd30};
            3: s = {rcm_pkg::WHEEL_I, rcm_pkg::WHEEL_I, rcm_pkg::WHEEL_I,
                    5'd0, 5'd0, 5'd0};
            default: s = {3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};
        endcase
        for (int idx = int'(rcm_pkg::REG_LEFT_WHEEL); idx <= int'(rcm_pkg::REG_RIGHT_RING);
             idx++) begin
            case (3'(idx))
                rcm_pkg::REG_LEFT_WHEEL:   value = 5'(s.left_wheel);
                rcm_pkg::REG_MIDDLE_WHEEL: value = 5'(s.middle_wheel);
                rcm_pkg::REG_RIGHT_WHEEL:  value = 5'(s.right_wheel);
                rcm_pkg::REG_LEFT_RING:    value = s.left_ring;
                rcm_pkg::REG_MIDDLE_RING:  value = s.middle_ring;
                default:                   value = s.right_ring;
            endcase
            i_cfg_wen   <= 1'b1;
            i_cfg_idx   <= 3'(idx);
            i_cfg_wdata <= value;
            @(posedge i_clk);
        end
        i_cfg_wen <= 1'b0;
    endtask

    // model update and result scoring, all on values sampled at the edge
    always @(posedge i_clk) begin : scoreboard
        t_command      seen;
        t_dial_reading want;
        if (!i_rst_n) begin
            slot_wheel[LEFT]   = rcm_pkg::WHEEL_I;
            slot_wheel[MIDDLE] = rcm_pkg::WHEEL_II;
            slot_wheel[RIGHT]  = rcm_pkg::WHEEL_III;
            for (int k = 0; k < 3; k++) begin
                slot_ring[k] = '0;
                rotor_pos[k] = '0;
            end
            for (int k = 0; k < rcm_pkg::ALPHA; k++) begin
                plugboard[k] = 5'(k);
            end
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    rcm_pkg::REG_LEFT_WHEEL:   slot_wheel[LEFT]   = i_cfg_wdata[2:0];
                    rcm_pkg::REG_MIDDLE_WHEEL: slot_wheel[MIDDLE] = i_cfg_wdata[2:0];
                    rcm_pkg::REG_RIGHT_WHEEL:  slot_wheel[RIGHT]  = i_cfg_wdata[2:0];
                    rcm_pkg::REG_LEFT_RING:    slot_ring[LEFT]    = i_cfg_wdata;
                    rcm_pkg::REG_MIDDLE_RING:  slot_ring[MIDDLE]  = i_cfg_wdata;
                    rcm_pkg::REG_RIGHT_RING:   slot_ring[RIGHT]   = i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (push && !full) begin
                seen.op         = i_operation;
                seen.letter     = i_letter;
                seen.partner    = i_partner_letter;
                seen.new_left   = i_new_left;
                seen.new_middle = i_new_middle;
                seen.new_right  = i_new_right;
                seen.has_want   = 1'b0;
                seen.want       = '0;
                want = crank_machine(seen);
                if (row_has_want) begin
                    want = row_want;
                end
                pending_readings.push_back(want);
            end
            if (pop && !empty) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch($sformatf("unexpected result letter %0d at %0d/%0d/%0d",
                                              o_out_letter, o_shown_left, o_shown_middle,
                                              o_shown_right));
                end else begin
                    want = pending_readings.pop_front();
                    if (o_out_letter !== want.letter) begin
                        report_mismatch($sformatf("result %0d out_letter got %0d want %0d",
                                                  results_seen, o_out_letter, want.letter));
                    end
                    if (o_shown_left !== want.left) begin
                        report_mismatch($sformatf("result %0d shown_left got %0d want %0d",
                                                  results_seen, o_shown_left, want.left));
                    end
                    if (o_shown_middle !== want.middle) begin
                        report_mismatch($sformatf("result %0d shown_middle got %0d want %0d",
                                                  results_seen, o_shown_middle, want.middle));
                    end
                    if (o_shown_right !== want.right) begin
                        report_mismatch($sformatf("result %0d shown_right got %0d want %0d",
                                                  results_seen, o_shown_right, want.right));
                    end
                end
                results_seen++;
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        // wheels I, II, III, rings zero, positions zero after reset
        add_row(rcm_pkg::OP_ENCIPHER, 0, 0, 0, 0, 0, 1'b1, 1, 0, 0, 1);
        add_row(rcm_pkg::OP_ENCIPHER, 0, 0, 0, 0, 0, 1'b1, 3, 0, 0, 2);
        add_row(rcm_pkg::OP_ENCIPHER, 31, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
        add_row(rcm_pkg::OP_PEEK, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
        add_row(rcm_pkg::OP_STEP, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 4);
        // right wheel at its notch, then the middle wheel double steps
        add_row(rcm_pkg::OP_LOAD, 0, 0, 0, 3, 21, 1'b1, 0, 0, 3, 21);
        add_row(rcm_pkg::OP_STEP, 0, 0, 0, 0, 0, 1'b1, 0, 0, 4, 22);
        add_row(rcm_pkg::OP_STEP, 0, 0, 0, 0, 0, 1'b1, 0, 1, 5, 23);
        add_row(rcm_pkg::OP_LOAD, 0, 0, 25, 25, 25, 1'b1, 0, 25, 25, 25);
        add_row(rcm_pkg::OP_STEP, 0, 0, 0, 0, 0, 1'b1, 0, 25, 25, 0);
        // positions off the alphabet load modulo 26
        add_row(rcm_pkg::OP_LOAD, 0, 0, 31, 26, 30, 1'b1, 0, 5, 0, 4);
        add_row(rcm_pkg::OP_PLUG, 0, 25, 0, 0, 0, 1'b1, 0, 5, 0, 4);
        add_row(rcm_pkg::OP_PLUG, 31, 3, 0, 0, 0, 1'b1, 0, 5, 0, 4);
        add_row(rcm_pkg::OP_PLUG, 3, 26, 0, 0, 0, 1'b1, 0, 5, 0, 4);
        add_row(rcm_pkg::OP_PLUG, 7, 7, 0, 0, 0, 1'b1, 0, 5, 0, 4);
        add_row(rcm_pkg::OP_ENCIPHER, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
        add_row(rcm_pkg::OP_PEEK, 25, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
        // re-plug a letter whose old partner stays wired to it
        add_row(rcm_pkg::OP_PLUG, 0, 1, 0, 0, 0, 1'b0, 0, 0, 0, 0);
        add_row(rcm_pkg::OP_ENCIPHER, 25, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
        add_row(OP_UNUSED_6, 3, 4, 9, 9, 9, 1'b0, 0, 0, 0, 0);
        add_row(OP_UNUSED_7, 31, 31, 31, 31, 31, 1'b0, 0, 0, 0, 0);
        add_row(rcm_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
        add_row(rcm_pkg::OP_LOAD, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0);
        add_row(rcm_pkg::OP_ENCIPHER, 0, 0, 0, 0, 0, 1'b1, 1, 0, 0, 1);
        add_row(rcm_pkg::OP_PEEK, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (drill_rows[n]) begin
            offer_command(drill_rows[n]);
        end
        settle_machine();

        // stall the result side long enough to back up into full
        idle_pct  = 0;
        stall_pct = 0;
        holds_asked++;
        repeat (BURST_ITEMS) offer_command(random_command());
        settle_machine();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_settings(p);
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 59;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 59;
                end
                default: begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            repeat (PHASE_ITEMS) offer_command(random_command());
            settle_machine();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: rotor_cipher_machine.f
+incdir+rtl/core
rtl/core/rcm_pkg.sv
rtl/core/rcm_queue.sv
rtl/core/rcm_front.sv
rtl/core/rcm_back.sv
rtl/core/rotor_cipher_machine.sv
rtl/core/rcm_checker.sv
tb/tb_rotor_cipher_machine.sv
